// File: src/uv_sphere_vertex_generator_macros.svh
// ----------------------------------------------------------------------------
// UV sphere vertex generator assertion macros
// Clocked property checks with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH

// check on every clock edge, reset included
`define UVS_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

// check on every clock edge while out of reset
`define UVS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`endif

// File: src/uvs_pkg.sv
// ----------------------------------------------------------------------------
// UV sphere vertex generator package
// Sizes, register codes, pipeline word types and shared arithmetic helpers.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int MAX_DIVISIONS = 1024;
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int DIV_BITS      = 32;
    localparam int CNT_W         = 11;
    localparam int DV_W          = 12;
    localparam int CW            = 34;
    localparam int LAT           = DIV_BITS + CORDIC_STAGES + 4;
    localparam int TEX_LEN       = CORDIC_STAGES + 3;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef enum logic [1:0] {
        REG_RING = 2'd0,
        REG_SEG  = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [DV_W-1:0]     rem;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] quo;
        logic [DV_W-1:0]     dv;
    } div_word_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } rot_t;

    typedef struct packed {
        logic [20:0] vidx;
        logic        err;
    } side_t;

    typedef struct packed {
        logic [16:0] u;
        logic [16:0] v;
    } tex_t;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] k);
        return $signed({2'b00, ATAN_Q30[k]});
    endfunction

    function automatic logic [15:0] sat16(input logic signed [CW-1:0] v);
        if (v > 34'sd32767) begin
            return 16'h7FFF;
        end else if (v < -34'sd32768) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

endpackage

// File: src/uvs_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step: shift in a numerator bit, compare, subtract, register.
// ----------------------------------------------------------------------------
module uvs_div_cell import uvs_pkg::*; (
    input  logic      aclk,
    input  logic      en,
    input  div_word_t d_in,
    output div_word_t d_out
);

    logic [DV_W:0] t;
    logic          ge;
    div_word_t     word_next;
    div_word_t     word_reg;

    always_comb begin
        t  = {d_in.rem, d_in.num[DIV_BITS-1]};
        ge = (t >= {1'b0, d_in.dv});
        word_next.rem = ge ? DV_W'(t - {1'b0, d_in.dv}) : t[DV_W-1:0];
        word_next.num = {d_in.num[DIV_BITS-2:0], 1'b0};
        word_next.quo = {d_in.quo[DIV_BITS-2:0], ge};
        word_next.dv  = d_in.dv;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign d_out = word_reg;

endmodule

// File: src/uvs_divider.sv
// ----------------------------------------------------------------------------
// Pipelined divider
// Row of divider cells, one quotient bit per cell, one word per cycle while en is high.
// ----------------------------------------------------------------------------
module uvs_divider import uvs_pkg::*; (
    input  logic                aclk,
    input  logic                en,
    input  logic [CNT_W-1:0]    num_hi,
    input  logic [DIV_BITS-1:0] num_lo,
    input  logic [DV_W-1:0]     dv,
    output logic [DIV_BITS-1:0] quo
);

    div_word_t chain [DIV_BITS+1];

    assign chain[0] = '{rem: DV_W'(num_hi), num: num_lo, quo: '0, dv: dv};

    for (genvar n = 0; n < DIV_BITS; n++) begin : g_cell
        uvs_div_cell u_cell (
            .aclk  (aclk),
            .en    (en),
            .d_in  (chain[n]),
            .d_out (chain[n+1])
        );
    end

    assign quo = chain[DIV_BITS].quo;

endmodule

// File: src/uvs_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation-mode micro-rotation with floor shifts, registered.
// ----------------------------------------------------------------------------
module uvs_cordic_cell import uvs_pkg::*; (
    input  logic       aclk,
    input  logic       en,
    input  logic [4:0] k,
    input  rot_t       r_in,
    output rot_t       r_out
);

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;
    rot_t                 rot_next;
    rot_t                 rot_reg;

    always_comb begin
        dx = r_in.y >>> k;
        dy = r_in.x >>> k;
        at = atan_q30(k);
        if (!r_in.z[CW-1]) begin
            rot_next.x = r_in.x - dx;
            rot_next.y = r_in.y + dy;
            rot_next.z = r_in.z - at;
        end else begin
            rot_next.x = r_in.x + dx;
            rot_next.y = r_in.y - dy;
            rot_next.z = r_in.z + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rot_reg <= rot_next;
        end
    end

    assign r_out = rot_reg;

endmodule

// File: src/uvs_cordic.sv
// ----------------------------------------------------------------------------
// Sine and cosine unit
// Row of CORDIC cells followed by a registered quadrant fold.
// ----------------------------------------------------------------------------
module uvs_cordic import uvs_pkg::*; (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [CW-1:0] z_in,
    input  logic [1:0]           quad_in,
    output logic signed [31:0]   c_out,
    output logic signed [31:0]   s_out
);

    rot_t                 chain [CORDIC_STAGES+1];
    logic [1:0]           quad_reg [CORDIC_STAGES];
    logic signed [CW-1:0] c_wide;
    logic signed [CW-1:0] s_wide;
    logic signed [31:0]   c_reg;
    logic signed [31:0]   s_reg;

    assign chain[0] = '{x: CORDIC_GAIN_Q30, y: '0, z: z_in};

    for (genvar n = 0; n < CORDIC_STAGES; n++) begin : g_cell
        uvs_cordic_cell u_cell (
            .aclk  (aclk),
            .en    (en),
            .k     (5'(n)),
            .r_in  (chain[n]),
            .r_out (chain[n+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quad_reg[0] <= quad_in;
            for (int n = 1; n < CORDIC_STAGES; n++) begin
                quad_reg[n] <= quad_reg[n-1];
            end
        end
    end

    always_comb begin
        case (quad_reg[CORDIC_STAGES-1])
            2'd0: begin
                c_wide = chain[CORDIC_STAGES].x;
                s_wide = chain[CORDIC_STAGES].y;
            end
            2'd1: begin
                c_wide = -chain[CORDIC_STAGES].y;
                s_wide = chain[CORDIC_STAGES].x;
            end
            2'd2: begin
                c_wide = -chain[CORDIC_STAGES].x;
                s_wide = -chain[CORDIC_STAGES].y;
            end
            default: begin
                c_wide = chain[CORDIC_STAGES].y;
                s_wide = -chain[CORDIC_STAGES].x;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg <= c_wide[31:0];
            s_reg <= s_wide[31:0];
        end
    end

    assign c_out = c_reg;
    assign s_out = s_reg;

endmodule

// File: src/uv_sphere_vertex_generator.sv
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Position, texture coordinates and flat index of one sphere vertex per word.
// ----------------------------------------------------------------------------
// channel   dir  tdata                                         tuser
// s_        in   ring_index, segment_index                     -
// m_        out  pos_x, pos_y, pos_z, tex_u, tex_v, vertex_idx index_error
// cfg_      in   write enable, index, data                     -
//
// One word per cycle in and out while the output is not stalled; the pipeline is
// made up of the 32-cell divider rows and the CORDIC cell rows.
// Reset clears the valid line and loads ring_count 16, segment_count 32.
// A stalled output word holds the whole pipeline; s_tready falls with it.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator import uvs_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // ring_index[10:0], segment_index[21:11]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v, vertex_index
    output logic [0:0]   m_tuser,   // index_error
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [10:0]  cfg_data
);

    logic [CNT_W-1:0]     ring_reg;
    logic [CNT_W-1:0]     seg_reg;
    logic                 adv;
    logic [LAT-1:0]       valid_reg;
    logic [CNT_W-1:0]     ri;
    logic [CNT_W-1:0]     sj;
    logic [CNT_W-1:0]     sj_phase;
    logic                 err_in;
    logic [DV_W-1:0]      seg_p1;
    logic [22:0]          vprod;
    logic [20:0]          vidx_in;
    side_t                side_reg [LAT-1];
    tex_t                 tex_reg [TEX_LEN];
    logic [DIV_BITS-1:0]  tq;
    logic [DIV_BITS-1:0]  pq;
    logic [DIV_BITS-1:0]  uq;
    logic [DIV_BITS-1:0]  vq;
    logic [60:0]          zt_sum;
    logic [60:0]          zp_sum;
    logic signed [CW-1:0] zt_reg;
    logic signed [CW-1:0] zp_reg;
    logic [1:0]           qt_reg;
    logic [1:0]           qp_reg;
    logic signed [31:0]   ct;
    logic signed [31:0]   st;
    logic signed [31:0]   cp;
    logic signed [31:0]   sp;
    logic signed [63:0]   px_reg;
    logic signed [63:0]   pz_reg;
    logic signed [31:0]   cy_reg;
    logic signed [63:0]   px_sh;
    logic signed [63:0]   pz_sh;
    logic signed [CW-1:0] py_sh;
    logic [103:0]         tdata_next;
    logic [103:0]         tdata_reg;
    logic                 tuser_reg;
    side_t                side_o;
    tex_t                 tex_o;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_reg <= 11'd16;
            seg_reg  <= 11'd32;
        end else if (cfg_we) begin
            if (cfg_index == REG_RING) begin
                ring_reg <= cfg_data;
            end else if (cfg_index == REG_SEG) begin
                seg_reg <= cfg_data;
            end
        end
    end

    assign adv      = m_tready || !valid_reg[LAT-1];
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[LAT-2:0], s_tvalid};
        end
    end

    always_comb begin
        ri       = s_tdata[10:0];
        sj       = s_tdata[21:11];
        sj_phase = (sj == seg_reg) ? '0 : sj;
        err_in   = (ring_reg == '0) || (seg_reg == '0) ||
                   (ring_reg > CNT_W'(MAX_DIVISIONS)) || (seg_reg > CNT_W'(MAX_DIVISIONS)) ||
                   (ri > ring_reg) || (sj > seg_reg);
        seg_p1   = {1'b0, seg_reg} + 12'd1;
        vprod    = {12'b0, ri} * {11'b0, seg_p1};
        vidx_in  = vprod[20:0] + {10'b0, sj};
    end

    uvs_divider u_div_theta (
        .aclk   (aclk),
        .en     (adv),
        .num_hi (ri),
        .num_lo ({21'b0, ring_reg}),
        .dv     ({ring_reg, 1'b0}),
        .quo    (tq)
    );

    uvs_divider u_div_phi (
        .aclk   (aclk),
        .en     (adv),
        .num_hi (sj_phase),
        .num_lo ({22'b0, seg_reg[10:1]}),
        .dv     ({1'b0, seg_reg}),
        .quo    (pq)
    );

    uvs_divider u_div_u (
        .aclk   (aclk),
        .en     (adv),
        .num_hi ('0),
        .num_lo ({5'b0, sj, 16'b0} + {22'b0, seg_reg[10:1]}),
        .dv     ({1'b0, seg_reg}),
        .quo    (uq)
    );

    uvs_divider u_div_v (
        .aclk   (aclk),
        .en     (adv),
        .num_hi ('0),
        .num_lo ({5'b0, ri, 16'b0} + {22'b0, ring_reg[10:1]}),
        .dv     ({1'b0, ring_reg}),
        .quo    (vq)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= '{vidx: vidx_in, err: err_in};
            for (int n = 1; n < LAT - 1; n++) begin
                side_reg[n] <= side_reg[n-1];
            end
            tex_reg[0] <= '{u: uq[16:0], v: vq[16:0]};
            for (int n = 1; n < TEX_LEN; n++) begin
                tex_reg[n] <= tex_reg[n-1];
            end
        end
    end

    // quarter turns to radians, Q2.30
    always_comb begin
        zt_sum = {31'b0, tq[29:0]} * {30'b0, HALF_PI_Q30} + 61'(1 << 29);
        zp_sum = {31'b0, pq[29:0]} * {30'b0, HALF_PI_Q30} + 61'(1 << 29);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            zt_reg <= $signed({3'b000, zt_sum[60:30]});
            zp_reg <= $signed({3'b000, zp_sum[60:30]});
            qt_reg <= tq[31:30];
            qp_reg <= pq[31:30];
        end
    end

    uvs_cordic u_cordic_theta (
        .aclk    (aclk),
        .en      (adv),
        .z_in    (zt_reg),
        .quad_in (qt_reg),
        .c_out   (ct),
        .s_out   (st)
    );

    uvs_cordic u_cordic_phi (
        .aclk    (aclk),
        .en      (adv),
        .z_in    (zp_reg),
        .quad_in (qp_reg),
        .c_out   (cp),
        .s_out   (sp)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            px_reg <= st * cp;
            pz_reg <= st * sp;
            cy_reg <= ct;
        end
    end

    always_comb begin
        side_o = side_reg[LAT-2];
        tex_o  = tex_reg[TEX_LEN-1];
        px_sh  = (px_reg + (64'sd1 <<< 44)) >>> 45;
        pz_sh  = (pz_reg + (64'sd1 <<< 44)) >>> 45;
        py_sh  = (CW'(cy_reg) + (34'sd1 <<< 14)) >>> 15;
        if (side_o.err) begin
            tdata_next = '0;
        end else begin
            tdata_next = {1'b0, side_o.vidx, tex_o.v, tex_o.u,
                          sat16(pz_sh[CW-1:0]), sat16(py_sh), sat16(px_sh[CW-1:0])};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tdata_reg <= tdata_next;
            tuser_reg <= side_o.err;
        end
    end

    assign m_tvalid   = valid_reg[LAT-1];
    assign m_tdata    = tdata_reg;
    assign m_tuser[0] = tuser_reg;

endmodule

// File: src/uvs_checker.sv
// ----------------------------------------------------------------------------
// UV sphere vertex generator checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "uv_sphere_vertex_generator_macros.svh"

module uvs_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic [0:0]   m_tuser
);

    `UVS_ASSERT_CLK(a_reset_clears, !aresetn |=> !m_tvalid, "valid after reset")
    `UVS_ASSERT_RST(a_err_zero, m_tvalid && m_tuser[0] |-> m_tdata == 104'd0, "error word not zero")
    `UVS_ASSERT_RST(a_tex_range, m_tvalid && !m_tuser[0] |-> m_tdata[64:48] <= 17'd65536 && m_tdata[81:65] <= 17'd65536, "texture out of range")
    `UVS_ASSERT_RST(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled word changed")

endmodule

bind uv_sphere_vertex_generator uvs_checker u_uvs_checker (.*);
